// ===== rtl/rolling_hash_chunker_defines.svh =====
// Assertion macros for the rolling hash chunker.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef ROLLING_HASH_CHUNKER_DEFINES_SVH
`define ROLLING_HASH_CHUNKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rhc_pkg.sv =====
// Shared constants, types and functions of the rolling hash chunker.
// No dependencies; every other file of the block but the defines header uses it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  localparam int unsigned WindowBytes = 32;
  localparam int unsigned OffsetBits  = 48;
  localparam int unsigned LengthBits  = 21;

  localparam int unsigned HashW     = 32;
  localparam int unsigned HashBitsW = 6;
  localparam int unsigned ChunkW    = 21;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [HashW-1:0] HashBase = 32'd587;

  localparam logic [HashBitsW-1:0] ResetHashBits = 6'd13;
  localparam logic [HashW-1:0]     ResetBoundary = 32'h0000_0087;
  localparam logic [ChunkW-1:0]    ResetMinChunk = 21'd2048;
  localparam logic [ChunkW-1:0]    ResetMaxChunk = 21'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    RegHashBits = 2'd0,
    RegBoundary = 2'd1,
    RegMinChunk = 2'd2,
    RegMaxChunk = 2'd3
  } cfg_reg_e;

  // Per-cycle control handed to every datapath unit.
  typedef struct packed {
    logic step;     // an item is processed this cycle
    logic restart;  // that item ends the stream
  } rhc_ctrl_t;

  // Base raised to the window length, modulo 2^HashW; evaluated at elaboration.
  function automatic logic [HashW-1:0] base_pow(input int unsigned n);
    logic [HashW-1:0] p;
    p = HashW'(1);
    for (int unsigned i = 0; i < n; i++) begin
      p = HashW'(p * HashBase);
    end
    return p;
  endfunction

  // Mask for a hash kept modulo 2^bits; widths above HashW act as HashW.
  function automatic logic [HashW-1:0] hash_mask(input logic [HashBitsW-1:0] bits);
    logic [HashW-1:0] m;
    if (bits >= HashBitsW'(HashW)) begin
      m = '1;
    end else begin
      m = (HashW'(1) << bits) - HashW'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rhc_if.sv =====
// Valid/ready stream interfaces of the rolling hash chunker.
// Depends on rhc_pkg for the default field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rhc_out_if #(
  parameter int unsigned OFFSET_BITS = rhc_pkg::OffsetBits,
  parameter int unsigned LENGTH_BITS = rhc_pkg::LengthBits
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] chunk_offset;
  logic [LENGTH_BITS-1:0] chunk_length;
  logic                   final_chunk;

  modport source (output valid, output chunk_offset, output chunk_length,
                  output final_chunk, input ready);
  modport sink   (input valid, input chunk_offset, input chunk_length,
                  input final_chunk, output ready);
endinterface

`default_nettype wire

// ===== rtl/rhc_window.sv =====
// Byte window of the chunker: a shift line plus fill tracking.
// Depends on rhc_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module rhc_window #(
  parameter int unsigned WINDOW_BYTES = rhc_pkg::WindowBytes
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rhc_pkg::rhc_ctrl_t ctrl_i,
  input  wire logic [7:0]       data_byte_i,
  output logic [7:0]            oldest_o,
  output logic                  full_o
);

  localparam int unsigned CntW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

  logic [7:0]      taps_q [WINDOW_BYTES];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full_q, full_d;
  logic            filled;

  // Until the window has filled, the byte leaving it reads as zero.
  assign filled   = !full_q && (cnt_q == CntW'(WINDOW_BYTES - 1));
  assign oldest_o = full_q ? taps_q[WINDOW_BYTES-1] : 8'd0;
  assign full_o   = full_q;

  always_comb begin
    cnt_d  = cnt_q;
    full_d = full_q;
    if (ctrl_i.restart) begin
      cnt_d  = '0;
      full_d = 1'b0;
    end else if (filled) begin
      cnt_d  = '0;
      full_d = 1'b1;
    end else if (!full_q) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else if (ctrl_i.step) begin
      cnt_q  <= cnt_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      taps_q[0] <= data_byte_i;
      for (int unsigned i = 1; i < WINDOW_BYTES; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhc_hash.sv =====
// Rolling hash register with its one-step update and boundary match.
// Depends on rhc_pkg for the base, the window power and the hash mask.
`timescale 1ns / 1ps
`default_nettype none

module rhc_hash #(
  parameter int unsigned WINDOW_BYTES = rhc_pkg::WindowBytes
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rhc_pkg::rhc_ctrl_t                  ctrl_i,
  input  wire logic [7:0]                          data_byte_i,
  input  wire logic [7:0]                          oldest_i,
  input  wire logic [rhc_pkg::HashBitsW-1:0]       hash_bits_i,
  input  wire logic [rhc_pkg::HashW-1:0]           boundary_i,
  output logic                                     hit_o
);

  localparam logic [rhc_pkg::HashW-1:0] PowWindow = rhc_pkg::base_pow(WINDOW_BYTES);

  logic [rhc_pkg::HashW-1:0] hash_q, hash_d;
  logic [rhc_pkg::HashW-1:0] base_term, old_term;

  always_comb begin
    base_term = rhc_pkg::HashW'(hash_q * rhc_pkg::HashBase);
    old_term  = rhc_pkg::HashW'(rhc_pkg::HashW'(oldest_i) * PowWindow);
    hash_d    = (base_term - old_term + rhc_pkg::HashW'(data_byte_i))
                & rhc_pkg::hash_mask(hash_bits_i);
  end

  assign hit_o = (hash_d == boundary_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else if (ctrl_i.step) begin
      hash_q <= ctrl_i.restart ? '0 : hash_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rhc_cut.sv =====
// Stream position, chunk start and length tracking with the cut decision.
// Depends on rhc_pkg for the control struct and the chunk limit width.
`timescale 1ns / 1ps
`default_nettype none

module rhc_cut #(
  parameter int unsigned OFFSET_BITS = rhc_pkg::OffsetBits,
  parameter int unsigned LENGTH_BITS = rhc_pkg::LengthBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rhc_pkg::rhc_ctrl_t             ctrl_i,
  input  wire logic                           full_i,
  input  wire logic                           hit_i,
  input  wire logic [rhc_pkg::ChunkW-1:0]     min_chunk_i,
  input  wire logic [rhc_pkg::ChunkW-1:0]     max_chunk_i,
  output logic                                emit_o,
  output logic [OFFSET_BITS-1:0]              chunk_offset_o,
  output logic [LENGTH_BITS-1:0]              chunk_length_o,
  output logic                                final_chunk_o
);

  localparam int unsigned WideW = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
  localparam int unsigned CmpW  = (LENGTH_BITS > rhc_pkg::ChunkW) ? LENGTH_BITS
                                                                  : rhc_pkg::ChunkW;

  logic [OFFSET_BITS-1:0] pos_q, start_q, len_q;
  logic [OFFSET_BITS-1:0] pos_next, len_next;
  logic [WideW-1:0]       len_wide;
  logic [LENGTH_BITS-1:0] len_sat;
  logic                   reach_max, reach_min, cut;

  always_comb begin
    pos_next  = OFFSET_BITS'(pos_q + 1'b1);
    len_next  = OFFSET_BITS'(len_q + 1'b1);
    len_wide  = WideW'(len_next);
    len_sat   = (len_wide > WideW'({LENGTH_BITS{1'b1}})) ? {LENGTH_BITS{1'b1}}
                                                          : LENGTH_BITS'(len_wide);
    reach_max = CmpW'(len_sat) >= CmpW'(max_chunk_i);
    reach_min = CmpW'(len_sat) >= CmpW'(min_chunk_i);
    cut       = full_i && (hit_i || reach_max) && reach_min;
  end

  assign emit_o         = ctrl_i.step && (ctrl_i.restart || cut);
  assign chunk_offset_o = start_q;
  assign chunk_length_o = len_sat;
  assign final_chunk_o  = ctrl_i.restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.restart) begin
        pos_q   <= '0;
        start_q <= '0;
        len_q   <= '0;
      end else if (cut) begin
        pos_q   <= pos_next;
        start_q <= pos_next;
        len_q   <= '0;
      end else begin
        pos_q <= pos_next;
        len_q <= len_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rolling_hash_chunker.sv =====
// Content-defined chunker: one byte accepted per cycle, sustained, unless results back up.
// A byte waits in the input register; the chunk it closes is offered from the result register.
// The hash recurrence (constant multiply, subtract, add, mask) sets the rate.
// Reset is asynchronous and active low; it clears the stream state and loads defaults.
// There is no clearing pass: the window uses a fill count instead.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_hash_chunker_defines.svh"

module rolling_hash_chunker #(
  parameter int unsigned WINDOW_BYTES = rhc_pkg::WindowBytes,
  parameter int unsigned OFFSET_BITS  = rhc_pkg::OffsetBits,
  parameter int unsigned LENGTH_BITS  = rhc_pkg::LengthBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rhc_in_if.sink                              in_chan,
  rhc_out_if.source                           out_chan,
  input  wire logic                           cfg_we_i,
  input  wire logic [rhc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rhc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned CmpW = (LENGTH_BITS > rhc_pkg::ChunkW) ? LENGTH_BITS
                                                                 : rhc_pkg::ChunkW;

  // Configuration registers. Software is to write these only while the block is idle,
  // which the block itself does not enforce; a new value then applies from the next byte onwards.
  logic [rhc_pkg::HashBitsW-1:0] hash_bits_q;
  logic [rhc_pkg::HashW-1:0]     boundary_q;
  logic [rhc_pkg::ChunkW-1:0]    min_chunk_q;
  logic [rhc_pkg::ChunkW-1:0]    max_chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_bits_q <= rhc_pkg::ResetHashBits;
      boundary_q  <= rhc_pkg::ResetBoundary;
      min_chunk_q <= rhc_pkg::ResetMinChunk;
      max_chunk_q <= rhc_pkg::ResetMaxChunk;
    end else if (cfg_we_i) begin
      unique case (rhc_pkg::cfg_reg_e'(cfg_idx_i))
        rhc_pkg::RegHashBits: hash_bits_q <= cfg_wdata_i[rhc_pkg::HashBitsW-1:0];
        rhc_pkg::RegBoundary: boundary_q  <= cfg_wdata_i[rhc_pkg::HashW-1:0];
        rhc_pkg::RegMinChunk: min_chunk_q <= cfg_wdata_i[rhc_pkg::ChunkW-1:0];
        rhc_pkg::RegMaxChunk: max_chunk_q <= cfg_wdata_i[rhc_pkg::ChunkW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. A request sits here while the window, hash and
  // cut logic work on it; it moves on whenever the result register has room, so
  // the input side is ready again in the same cycle.
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_eos_q;
  logic       in_fire, out_free, step;

  // Result register. It parts the two sides: a result waiting for its taker does
  // not stop a byte from entering the input register while that register is empty.
  logic                   out_valid_q;
  logic [OFFSET_BITS-1:0] res_offset_q;
  logic [LENGTH_BITS-1:0] res_length_q;
  logic                   res_final_q;

  rhc_pkg::rhc_ctrl_t     ctrl;
  logic [7:0]             oldest;
  logic                   win_full, hit, emit;
  logic [OFFSET_BITS-1:0] cut_offset;
  logic [LENGTH_BITS-1:0] cut_length;
  logic                   cut_final;

  assign out_free      = !out_valid_q || out_chan.ready;
  assign step          = a_valid_q && out_free;
  assign in_chan.ready = !a_valid_q || step;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign ctrl.step    = step;
  assign ctrl.restart = step && a_eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (step) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_byte_q <= in_chan.data_byte;
      a_eos_q  <= in_chan.end_of_stream;
    end
  end

  // The window supplies the byte that leaves the hash span; it reads as zero
  // until the first window's worth of bytes of a stream has arrived.
  rhc_window #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .data_byte_i (a_byte_q),
    .oldest_o    (oldest),
    .full_o      (win_full)
  );

  rhc_hash #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .data_byte_i (a_byte_q),
    .oldest_i    (oldest),
    .hash_bits_i (hash_bits_q),
    .boundary_i  (boundary_q),
    .hit_o       (hit)
  );

  // Boundary checks only begin with the byte after the one that filled the window.
  // The end-of-stream byte always closes a final chunk, even during the fill.
  rhc_cut #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_cut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .full_i         (win_full),
    .hit_i          (hit),
    .min_chunk_i    (min_chunk_q),
    .max_chunk_i    (max_chunk_q),
    .emit_o         (emit),
    .chunk_offset_o (cut_offset),
    .chunk_length_o (cut_length),
    .final_chunk_o  (cut_final)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_offset_q <= cut_offset;
      res_length_q <= cut_length;
      res_final_q  <= cut_final;
    end
  end

  assign out_chan.valid        = out_valid_q;
  assign out_chan.chunk_offset = res_offset_q;
  assign out_chan.chunk_length = res_length_q;
  assign out_chan.final_chunk  = res_final_q;

  // An empty result register must never hold back the input side.
  `RHC_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_chan.ready,
                  "input stalled with empty result register")
  // Every chunk holds at least the byte that closed it.
  `RHC_ASSERT_NOW(a_len_nonzero, out_valid_q, res_length_q != '0, "zero-length chunk offered")
  // A cut other than the end of stream respects the minimum chunk length.
  `RHC_ASSERT_NOW(a_len_min, out_valid_q && !res_final_q,
                  CmpW'(res_length_q) >= CmpW'(min_chunk_q), "chunk cut below minimum length")
  // The end-of-stream byte always produces a final chunk in the next cycle.
  `RHC_ASSERT_NEXT(a_eos_final, step && a_eos_q, out_valid_q && res_final_q,
                   "end of stream gave no final chunk")

endmodule

`default_nettype wire
